### src/prd_pkg.sv
// ----------------------------------------------------------------------------
// Capture record deframer package
// Shared types and constants for the capture file deframer.
// ----------------------------------------------------------------------------
package prd_pkg;

    // Parser phases, one-hot coded.
    typedef enum logic [3:0] {
        PH_GLOBAL  = 4'b0001,
        PH_RECORD  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DRAIN   = 4'b1000
    } phase_t;

    // Status codes reported on the finishing item.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_NANOSEC   = 4'd2;
    localparam logic [3:0] ST_SWAPPED   = 4'd3;
    localparam logic [3:0] ST_NOT_CAP   = 4'd4;
    localparam logic [3:0] ST_VERSION   = 4'd5;
    localparam logic [3:0] ST_TRUNC_CAP = 4'd6;
    localparam logic [3:0] ST_CORRUPT   = 4'd7;
    localparam logic [3:0] ST_EMPTY     = 4'd8;

    // Magic numbers and the supported version word.
    localparam logic [31:0] MAGIC_US      = 32'hA1B2C3D4;
    localparam logic [31:0] MAGIC_NS      = 32'hA1B23C4D;
    localparam logic [31:0] MAGIC_US_SWAP = 32'hD4C3B2A1;
    localparam logic [31:0] MAGIC_NS_SWAP = 32'h4D3CB2A1;
    localparam logic [31:0] VERSION_2_4   = 32'h00040002;

    // Header byte positions.
    localparam logic [4:0] GLOBAL_LAST_POS = 5'd23;
    localparam logic [4:0] RECORD_LAST_POS = 5'd15;
    localparam logic [4:0] LINK_FIRST_POS  = 5'd20;

    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

    // One result item.
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  payload_byte;
        logic        packet_first;
        logic        packet_last;
        logic [31:0] packet_number;
        logic [31:0] stamp_seconds;
        logic [31:0] stamp_micros;
        logic [31:0] link_kind;
        logic        finished;
        logic [3:0]  status;
    } result_t;

endpackage

### src/prd_core.sv
// ----------------------------------------------------------------------------
// Capture record deframer core
// Parser state and the per-byte step logic; produces at most one result
// for each accepted byte.
// ----------------------------------------------------------------------------
module prd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           file_byte,
    input  logic                 file_end,
    input  logic [31:0]          packet_limit,
    output logic                 res_valid,
    output prd_pkg::result_t     res
);

    prd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] version_reg, version_next;
    logic [31:0] link_reg, link_next;
    logic [31:0] seconds_reg, seconds_next;
    logic [31:0] micros_reg, micros_next;
    logic [31:0] cap_len_reg, cap_len_next;
    logic [31:0] full_len_reg, full_len_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] seen_reg, seen_next;

    logic        fire_finish;
    logic        fire_complete;
    logic        fire_data;
    logic        do_reset;
    logic [3:0]  fin_status;
    logic [3:0]  hdr_status;
    logic        comp_dv;
    logic        comp_first;
    logic [31:0] seen_inc;
    logic        comp_fin;

    // Little-endian word assembly: new byte enters at the top.
    function automatic logic [31:0] shift_in(input logic [31:0] word,
                                             input logic [7:0] b);
        shift_in = {b, word[31:8]};
    endfunction

    // Global header check, in priority order.
    function automatic logic [3:0] header_status(input logic [31:0] magic,
                                                 input logic [31:0] version);
        if (magic == prd_pkg::MAGIC_NS)
            header_status = prd_pkg::ST_NANOSEC;
        else if (magic == prd_pkg::MAGIC_US_SWAP || magic == prd_pkg::MAGIC_NS_SWAP)
            header_status = prd_pkg::ST_SWAPPED;
        else if (magic != prd_pkg::MAGIC_US)
            header_status = prd_pkg::ST_NOT_CAP;
        else if (version != prd_pkg::VERSION_2_4)
            header_status = prd_pkg::ST_VERSION;
        else
            header_status = prd_pkg::ST_OK;
    endfunction

    // Saturating packet count after completing a packet.
    assign seen_inc = (seen_reg != prd_pkg::COUNT_MAX) ? seen_reg + 32'd1 : seen_reg;
    assign comp_fin = ((packet_limit != 32'd0) && (seen_inc == packet_limit)) || file_end;
    // The magic and version words are complete long before the header's last byte.
    assign hdr_status = header_status(magic_reg, version_reg);

    // Step logic for one byte.
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        magic_next    = magic_reg;
        version_next  = version_reg;
        link_next     = link_reg;
        seconds_next  = seconds_reg;
        micros_next   = micros_reg;
        cap_len_next  = cap_len_reg;
        full_len_next = full_len_reg;
        left_next     = left_reg;
        seen_next     = seen_reg;
        fire_finish   = 1'b0;
        fire_complete = 1'b0;
        fire_data     = 1'b0;
        do_reset      = 1'b0;
        fin_status    = prd_pkg::ST_OK;
        comp_dv       = 1'b0;
        comp_first    = 1'b0;

        case (phase_reg)
            prd_pkg::PH_GLOBAL:
            begin
                if (pos_reg < 5'd4)
                    magic_next = shift_in(magic_reg, file_byte);
                else if (pos_reg < 5'd8)
                    version_next = shift_in(version_reg, file_byte);
                else if (pos_reg >= prd_pkg::LINK_FIRST_POS)
                    link_next = shift_in(link_reg, file_byte);
                if (pos_reg >= prd_pkg::GLOBAL_LAST_POS)
                begin
                    if (hdr_status != prd_pkg::ST_OK)
                    begin
                        fire_finish = 1'b1;
                        fin_status  = hdr_status;
                    end
                    else if (file_end)
                    begin
                        fire_finish = 1'b1;
                        fin_status  = prd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        phase_next = prd_pkg::PH_RECORD;
                        pos_next   = 5'd0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                    if (file_end)
                    begin
                        fire_finish = 1'b1;
                        fin_status  = prd_pkg::ST_SHORT;
                    end
                end
            end

            prd_pkg::PH_RECORD:
            begin
                if (pos_reg < 5'd4)
                    seconds_next = shift_in(seconds_reg, file_byte);
                else if (pos_reg < 5'd8)
                    micros_next = shift_in(micros_reg, file_byte);
                else if (pos_reg < 5'd12)
                    cap_len_next = shift_in(cap_len_reg, file_byte);
                else
                    full_len_next = shift_in(full_len_reg, file_byte);
                if (pos_reg < prd_pkg::RECORD_LAST_POS)
                begin
                    pos_next = pos_reg + 5'd1;
                    if (file_end)
                    begin
                        fire_finish = 1'b1;
                        if (packet_limit == 32'd0)
                            fin_status = prd_pkg::ST_CORRUPT;
                        else if (seen_reg == 32'd0)
                            fin_status = prd_pkg::ST_EMPTY;
                        else
                            fin_status = prd_pkg::ST_OK;
                    end
                end
                else
                begin
                    pos_next = 5'd0;
                    if (cap_len_next != full_len_next)
                    begin
                        fire_finish = 1'b1;
                        fin_status  = prd_pkg::ST_TRUNC_CAP;
                    end
                    else if (cap_len_next == 32'd0)
                    begin
                        fire_complete = 1'b1;
                        comp_first    = 1'b1;
                    end
                    else if (file_end)
                    begin
                        fire_finish = 1'b1;
                        fin_status  = prd_pkg::ST_CORRUPT;
                    end
                    else
                    begin
                        left_next  = cap_len_next;
                        phase_next = prd_pkg::PH_PAYLOAD;
                    end
                end
            end

            prd_pkg::PH_PAYLOAD:
            begin
                comp_first = (left_reg == cap_len_reg);
                if (left_reg <= 32'd1)
                begin
                    left_next     = 32'd0;
                    fire_complete = 1'b1;
                    comp_dv       = 1'b1;
                end
                else
                begin
                    left_next = left_reg - 32'd1;
                    if (file_end)
                    begin
                        fire_finish = 1'b1;
                        fin_status  = prd_pkg::ST_CORRUPT;
                    end
                    else
                        fire_data = 1'b1;
                end
            end

            prd_pkg::PH_DRAIN:
            begin
                if (file_end)
                    do_reset = 1'b1;
            end

            default:
            begin
                do_reset = 1'b1;
            end
        endcase

        // End of parsing for this file: wait for file end, or restart now.
        if (fire_finish)
        begin
            if (file_end)
                do_reset = 1'b1;
            else
                phase_next = prd_pkg::PH_DRAIN;
        end

        // Packet completion decides whether parsing continues.
        if (fire_complete)
        begin
            seen_next = seen_inc;
            if (comp_fin)
            begin
                if (file_end)
                    do_reset = 1'b1;
                else
                    phase_next = prd_pkg::PH_DRAIN;
            end
            else
            begin
                phase_next = prd_pkg::PH_RECORD;
                pos_next   = 5'd0;
            end
        end
    end

    // Result item, built from the updated header words.
    always_comb
    begin
        res_valid         = fire_finish | fire_complete | fire_data;
        res.data_valid    = fire_data | (fire_complete & comp_dv);
        res.payload_byte  = (fire_data | (fire_complete & comp_dv)) ? file_byte : 8'd0;
        res.packet_first  = (fire_data | fire_complete) & comp_first;
        res.packet_last   = fire_complete;
        res.packet_number = seen_reg;
        res.stamp_seconds = seconds_next;
        res.stamp_micros  = micros_next;
        res.link_kind     = link_next;
        res.finished      = fire_finish | (fire_complete & comp_fin);
        res.status        = fire_finish ? fin_status : prd_pkg::ST_OK;
    end

    // State registers, advanced once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= prd_pkg::PH_GLOBAL;
            pos_reg      <= 5'd0;
            magic_reg    <= 32'd0;
            version_reg  <= 32'd0;
            link_reg     <= 32'd0;
            seconds_reg  <= 32'd0;
            micros_reg   <= 32'd0;
            cap_len_reg  <= 32'd0;
            full_len_reg <= 32'd0;
            left_reg     <= 32'd0;
            seen_reg     <= 32'd0;
        end
        else if (step)
        begin
            if (do_reset)
            begin
                phase_reg    <= prd_pkg::PH_GLOBAL;
                pos_reg      <= 5'd0;
                magic_reg    <= 32'd0;
                version_reg  <= 32'd0;
                link_reg     <= 32'd0;
                seconds_reg  <= 32'd0;
                micros_reg   <= 32'd0;
                cap_len_reg  <= 32'd0;
                full_len_reg <= 32'd0;
                left_reg     <= 32'd0;
                seen_reg     <= 32'd0;
            end
            else
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                magic_reg    <= magic_next;
                version_reg  <= version_next;
                link_reg     <= link_next;
                seconds_reg  <= seconds_next;
                micros_reg   <= micros_next;
                cap_len_reg  <= cap_len_next;
                full_len_reg <= full_len_next;
                left_reg     <= left_next;
                seen_reg     <= seen_next;
            end
        end
    end

endmodule

### src/pcap_record_deframer_unit.sv
// ----------------------------------------------------------------------------
// Capture record deframer
// Parses a classic capture file streamed one byte per item and emits the
// payload bytes of each record with packet marks, index and timestamps.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle and answers each byte with
// zero or one result item, in the next cycle, from a single output register.
// A byte is accepted whenever that register is empty or is being taken in
// the same cycle, so in_ready follows out_ready combinationally and a
// stalled output holds the input side for exactly as long. The packet limit
// register is written through its own channel, which is always ready, and
// should be changed only while the block is idle; its current value is used
// at every check. After reset no clearing pass is needed.
module pcap_record_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input byte channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        file_end,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic        data_valid,
    output logic [7:0]  payload_byte,
    output logic        packet_first,
    output logic        packet_last,
    output logic [31:0] packet_number,
    output logic [31:0] stamp_seconds,
    output logic [31:0] stamp_micros,
    output logic [31:0] link_kind,
    output logic        finished,
    output logic [3:0]  status
);

    logic [31:0]      limit_reg;
    logic             out_valid_reg, out_valid_next;
    prd_pkg::result_t out_reg;
    prd_pkg::result_t step_res;
    logic             step_res_valid;
    logic             in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // Packet limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 32'd0;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    // Parser core.
    prd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_fire),
        .file_byte    (file_byte),
        .file_end     (file_end),
        .packet_limit (limit_reg),
        .res_valid    (step_res_valid),
        .res          (step_res)
    );

    // Output register: loaded on each accepted item that yields a result.
    assign out_valid_next = in_fire ? step_res_valid : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step_res_valid)
            out_reg <= step_res;
    end

    // Result ports.
    assign out_valid     = out_valid_reg;
    assign data_valid    = out_reg.data_valid;
    assign payload_byte  = out_reg.payload_byte;
    assign packet_first  = out_reg.packet_first;
    assign packet_last   = out_reg.packet_last;
    assign packet_number = out_reg.packet_number;
    assign stamp_seconds = out_reg.stamp_seconds;
    assign stamp_micros  = out_reg.stamp_micros;
    assign link_kind     = out_reg.link_kind;
    assign finished      = out_reg.finished;
    assign status        = out_reg.status;

endmodule
